>>> design/ebvm_pkg.sv
// shared types and constants for the eight-bit vm execute core
// no dependencies
package ebvm_pkg;

  localparam int MemBytesDefault   = 4096;
  localparam int StackDepthDefault = 16;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_WAIT      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_STACK,
    S_BCD1,
    S_BCD2,
    S_STORE,
    S_LOADA,
    S_LOADB,
    S_CLEAR,
    S_OUT
  } state_t;

endpackage

>>> design/eight_bit_vm_execute_core_unit.sv
// eight-bit vm execute core: top level
// depends on ebvm_pkg
// One instruction word is taken at a time. A simple instruction passes through the states
// accept, V register read, execute and result. Calls and returns also pass the stack state for
// the stack memory. BCD adds the BCD1 and BCD2 states for its second and third byte writes.
// Block store and block load move V0 to Vx, one register per cycle through the single
// byte-memory port; block load first passes a state that starts the first byte read. The VF
// write of a flag instruction falls in the result cycle and costs nothing. After reset the
// byte memory and the V registers are cleared one entry a cycle, and no word is accepted
// until it is done. The result stays in an output register until it is taken.
module eight_bit_vm_execute_core_unit #(
  parameter int MEM_BYTES   = ebvm_pkg::MemBytesDefault,
  parameter int STACK_DEPTH = ebvm_pkg::StackDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] opcode_word,
  input  logic        key_down,
  input  logic [3:0]  key_code,
  input  logic [7:0]  random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] next_pc,
  output logic [2:0]  status,
  output logic        clear_screen,
  output logic        sound_active,
  output logic [15:0] index_value
);
  import ebvm_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam int SW = $clog2(STACK_DEPTH);

  state_t state, state_next;

  logic [15:0] op;
  logic        key;
  logic [3:0]  kcode;
  logic [7:0]  rnd;
  logic [15:0] index_reg;
  logic [11:0] pc;
  logic [4:0]  stack_level;
  logic [7:0]  delay_value, sound_value;
  logic [7:0]  vx, vy;
  logic [3:0]  cnt;
  logic [AW-1:0] clr_addr;
  logic [2:0]  st_res;
  logic        clr_res;

  // register file memory, read port a and b
  logic [7:0] vmem [16];
  logic       vwe;
  logic [3:0] vwa;
  logic [7:0] vwd;
  logic [3:0] vra, vrb;
  logic [7:0] vqa, vqb;

  // byte memory
  logic [7:0]    bmem [MEM_BYTES];
  logic          bwe;
  logic [AW-1:0] bwa, bra;
  logic [7:0]    bwd, bq;

  // return stack memory
  logic [11:0]   smem [STACK_DEPTH];
  logic          swe;
  logic [SW-1:0] sa;
  logic [11:0]   sq;

  logic [3:0] x, y;
  logic [7:0] kk;
  logic [11:0] nnn, seq, skp;
  assign x   = op[11:8];
  assign y   = op[7:4];
  assign kk  = op[7:0];
  assign nnn = op[11:0];
  assign seq = pc + 12'd2;
  assign skp = pc + 12'd4;

  always_ff @(posedge clk) begin
    if (vwe) vmem[vwa] <= vwd;
    vqa <= vmem[vra];
    vqb <= vmem[vrb];
    if (bwe) bmem[bwa] <= bwd;
    bq <= bmem[bra];
    if (swe) smem[sa] <= seq;
    sq <= smem[sa];
  end

  // bcd digits, value below 256
  logic [7:0] hund, tens, ones, rem1;
  always_comb begin
    hund = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
    rem1 = vx - 8'((hund * 8'd100));
    tens = 8'((16'(rem1) * 16'd205) >> 11);
    ones = rem1 - 8'(tens * 8'd10);
  end

  logic [AW-1:0] ibase;
  assign ibase = index_reg[AW-1:0];

  // execute decode, v0 sits on read port a during execute
  logic [7:0]  wval;
  logic        wen, fen;
  logic [7:0]  fval;
  logic [11:0] npc;
  logic [2:0]  st;
  logic        clr;
  logic [8:0]  sum;
  logic        keq;
  always_comb begin
    wen = 1'b0; fen = 1'b0; wval = '0; fval = '0;
    npc = seq; st = ST_OK; clr = 1'b0;
    sum = {1'b0, vx} + {1'b0, vy};
    keq = key && (vx == {4'd0, kcode});
    case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) clr = 1'b1;
        else if (op == 16'h00EE) begin
          if (stack_level == 5'd0) begin st = ST_UNDERFLOW; npc = pc; end
        end else st = ST_UNKNOWN;
      end
      4'h1: npc = nnn;
      4'h2: begin
        if (stack_level >= 5'(STACK_DEPTH)) begin st = ST_OVERFLOW; npc = pc; end
        else npc = nnn;
      end
      4'h3: if (vx == kk) npc = skp;
      4'h4: if (vx != kk) npc = skp;
      4'h5: if (vx == vy) npc = skp;
      4'h6: begin wen = 1'b1; wval = kk; end
      4'h7: begin wen = 1'b1; wval = vx + kk; end
      4'h8: begin
        case (op[3:0])
          4'h0: begin wen = 1'b1; wval = vy; end
          4'h1: begin wen = 1'b1; wval = vx | vy; end
          4'h2: begin wen = 1'b1; wval = vx & vy; end
          4'h3: begin wen = 1'b1; wval = vx ^ vy; end
          4'h4: begin wen = 1'b1; wval = sum[7:0]; fen = 1'b1; fval = {7'd0, sum[8]}; end
          4'h5: begin
            wen = 1'b1; wval = vx - vy; fen = 1'b1; fval = {7'd0, vx >= vy};
          end
          4'h6: begin wen = 1'b1; wval = vx >> 1; fen = 1'b1; fval = {7'd0, vx[0]}; end
          4'h7: begin
            wen = 1'b1; wval = vy - vx; fen = 1'b1; fval = {7'd0, vy >= vx};
          end
          4'hE: begin wen = 1'b1; wval = vx << 1; fen = 1'b1; fval = {7'd0, vx[7]}; end
          default: st = ST_UNKNOWN;
        endcase
      end
      4'h9: if (vx != vy) npc = skp;
      4'hA: ;
      4'hB: npc = nnn + {4'd0, vqa};
      4'hC: begin wen = 1'b1; wval = rnd & kk; end
      4'hD: ;
      4'hE: begin
        if (kk == 8'h9E) begin if (keq) npc = skp; end
        else if (kk == 8'hA1) begin if (!keq) npc = skp; end
        else st = ST_UNKNOWN;
      end
      default: begin
        case (kk)
          8'h07: begin wen = 1'b1; wval = delay_value; end
          8'h0A: begin
            if (key) begin wen = 1'b1; wval = {4'd0, kcode}; end
            else begin st = ST_WAIT; npc = pc; end
          end
          8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65: ;
          default: st = ST_UNKNOWN;
        endcase
      end
    endcase
  end

  logic is_f, is_call, is_ret, is_bcd, is_st, is_ld;
  assign is_f    = op[15:12] == 4'hF;
  assign is_call = op[15:12] == 4'h2 && st == ST_OK;
  assign is_ret  = op == 16'h00EE && st == ST_OK;
  assign is_bcd  = is_f && kk == 8'h33;
  assign is_st   = is_f && kk == 8'h55;
  assign is_ld   = is_f && kk == 8'h65;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == AW'(MEM_BYTES - 1)) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_READ;
      S_READ:  state_next = S_EXEC;
      S_EXEC: begin
        if (is_call || is_ret) state_next = S_STACK;
        else if (is_bcd) state_next = S_BCD1;
        else if (is_st) state_next = S_STORE;
        else if (is_ld) state_next = S_LOADA;
        else state_next = S_OUT;
      end
      S_STACK: state_next = S_OUT;
      S_BCD1:  state_next = S_BCD2;
      S_BCD2:  state_next = S_OUT;
      S_STORE: if (cnt == x) state_next = S_OUT;
      S_LOADA: state_next = S_LOADB;
      S_LOADB: if (cnt == x) state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // flag writes are deferred: vf is written after the value, from a held copy
  logic        fpend;
  logic [7:0]  fhold;

  // memory controls
  always_comb begin
    vra = x; vrb = y;
    vwe = 1'b0; vwa = x; vwd = wval;
    bwe = 1'b0; bwa = ibase; bwd = '0; bra = ibase;
    swe = 1'b0; sa = stack_level[SW-1:0];
    case (state)
      S_CLEAR: begin
        bwe = 1'b1; bwa = clr_addr;
        vwe = 1'b1; vwa = clr_addr[3:0]; vwd = '0;
      end
      S_IDLE: begin vra = opcode_word[11:8]; vrb = opcode_word[7:4]; end
      S_READ: vra = 4'd0;
      S_EXEC: begin
        vwe = wen;
        vra = 4'd0;
        if (is_ret) sa = SW'(stack_level - 5'd1);
        swe = is_call;
        if (is_bcd) begin bwe = 1'b1; bwd = hund; end
      end
      S_BCD1: begin bwe = 1'b1; bwa = ibase + AW'(1); bwd = tens; end
      S_BCD2: begin bwe = 1'b1; bwa = ibase + AW'(2); bwd = ones; end
      S_STORE: begin
        vra = cnt + 4'd1;
        bwe = 1'b1; bwa = ibase + AW'(cnt); bwd = vqa;
      end
      S_LOADA: bra = ibase;
      S_LOADB: begin
        bra = ibase + AW'(cnt) + AW'(1);
        vwe = 1'b1; vwa = cnt; vwd = bq;
      end
      default: ;
    endcase
    if (fpend) begin
      vwe = 1'b1; vwa = 4'hF; vwd = fhold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      index_reg <= '0; pc <= '0; stack_level <= '0;
      delay_value <= '0; sound_value <= '0;
      fpend <= 1'b0;
    end else begin
      state <= state_next;
      fpend <= 1'b0;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state == S_EXEC) begin
        fpend <= fen;
        if (op[15:12] == 4'hA) index_reg <= {4'd0, nnn};
        if (is_f && kk == 8'h15) delay_value <= vx;
        if (is_f && kk == 8'h18) sound_value <= vx;
        if (is_f && kk == 8'h1E) index_reg <= index_reg + {8'd0, vx};
        if (is_f && kk == 8'h29) index_reg <= {12'd0, vx[3:0]} * 16'd5;
        if (is_call) stack_level <= stack_level + 5'd1;
        if (is_ret) stack_level <= stack_level - 5'd1;
        pc <= npc;
      end
      if (state == S_STACK && op == 16'h00EE) pc <= sq;
    end
  end

  // vf value held for the write in the result cycle
  always_ff @(posedge clk) begin
    if (state == S_EXEC) fhold <= fval;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op <= opcode_word; key <= key_down; kcode <= key_code; rnd <= random_byte;
    end
    if (state == S_EXEC) begin
      st_res <= st; clr_res <= clr;
    end
    if (state == S_READ) begin vx <= vqa; vy <= vqb; end
    if (state == S_EXEC || state == S_LOADA) cnt <= '0;
    else if (state == S_STORE || state == S_LOADB) cnt <= cnt + 4'd1;
  end

  assign in_ready     = state == S_IDLE;
  assign out_valid    = state == S_OUT;
  assign next_pc      = pc;
  assign status       = st_res;
  assign clear_screen = clr_res;
  assign sound_active = sound_value != 8'd0;
  assign index_value  = index_reg;

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output both open");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_level <= 5'(STACK_DEPTH)) else $error("stack level out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc))
    else $error("result dropped");
endmodule
